/* rtl/core/image_permute_xor_cipher_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the image cipher block.
// Each macro expects signals clk and rst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef IMAGE_PERMUTE_XOR_CIPHER_UNIT_ASSERT_SVH
`define IMAGE_PERMUTE_XOR_CIPHER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define IPX_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipx assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define IPX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipx assertion failed");

// Condition must hold at every clock edge out of reset.
`define IPX_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ipx assertion failed");

`else

`define IPX_ASSERT_SAME(lbl, ante, cons)
`define IPX_ASSERT_NEXT(lbl, ante, cons)
`define IPX_ASSERT_ALWAYS(lbl, cond)

`endif

`endif

/* rtl/core/ipx_pkg.sv */
// ---------------------------------------------------------------------------
// ipx_pkg
// Types, codes and helper functions shared by the image cipher block.
// ---------------------------------------------------------------------------
package ipx_pkg;

  localparam int PRNG_W     = 32;
  localparam int PIX_W      = 24;
  localparam int CH_W       = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int PCOUNT_W   = 13;

  // xorshift32 shift amounts.
  localparam int XS_A = 13;
  localparam int XS_B = 17;
  localparam int XS_C = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SEED        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = CFG_IDX_W'(3);

  // Request commands.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_LOADED = 2'd1;
  localparam logic [1:0] ST_ALL_READ   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [PRNG_W-1:0]   SEED_RESET   = 32'd1;
  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 13'd4096;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_WAIT,
    S_INIT,
    S_SH_STEP,
    S_SH_DIV,
    S_SH_RDI,
    S_SH_WR1,
    S_SH_WR2,
    S_EP_RD,
    S_EP_WR,
    S_EC_RD,
    S_EC_WR,
    S_DC_RD,
    S_DC_WR,
    S_DP_RD,
    S_DP_RD2,
    S_DP_WR
  } ipx_state_t;

  // One xorshift32 step.
  function automatic logic [PRNG_W-1:0] xs32(input logic [PRNG_W-1:0] x);
    logic [PRNG_W-1:0] y;
    y = x ^ (x << XS_A);
    y = y ^ (y >> XS_B);
    y = y ^ (y << XS_C);
    return y;
  endfunction

  // Bytes 1..3 of a word placed at the red, green and blue positions.
  function automatic logic [PIX_W-1:0] key_mask(input logic [PRNG_W-1:0] w);
    return {w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

/* rtl/core/ipx_if.sv */
// ---------------------------------------------------------------------------
// Channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
interface ipx_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, command, red, green, blue, input ready);
  modport sink   (input valid, command, red, green, blue, output ready);
endinterface

interface ipx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       last;
  logic [1:0] status;

  modport source (output valid, red_out, green_out, blue_out, last, status, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, last, status, output ready);
endinterface

interface ipx_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/ipx_ram.sv */
// ---------------------------------------------------------------------------
// ipx_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module ipx_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/ipx_mod_unit.sv */
// ---------------------------------------------------------------------------
// ipx_mod_unit
// Bit-serial remainder unit: 32-bit dividend modulo a narrow divisor.
// ---------------------------------------------------------------------------
module ipx_mod_unit #(
  parameter int VW = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ipx_pkg::PRNG_W-1:0] dividend,
  input  logic [VW-1:0]              divisor,
  output logic                       busy,
  output logic                       done,
  output logic [VW-1:0]              rem
);
  import ipx_pkg::*;

  localparam int CNT_W = $clog2(PRNG_W);

  logic [PRNG_W-1:0] q_r,    q_nxt;
  logic [VW-1:0]     rem_r,  rem_nxt;
  logic [VW-1:0]     dvs_r,  dvs_nxt;
  logic [CNT_W-1:0]  cnt_r,  cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [VW:0]       trial;

  // One restoring step per cycle, most significant dividend bit first.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[PRNG_W-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        trial = trial - {1'b0, dvs_r};
      end
      rem_nxt = trial[VW-1:0];
      q_nxt   = q_r << 1;
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(PRNG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* rtl/core/image_permute_xor_cipher_unit.sv */
// ---------------------------------------------------------------------------
// image_permute_xor_cipher_unit
// Loads an RGB image, shuffles it with a xorshift32 keystream and XOR-chains
// the pixels (or undoes both), then returns the result pixel by pixel.
// ---------------------------------------------------------------------------
//  Channel    Dir  Carries
//  in_chan    in   command, red, green, blue (load pixel or read request)
//  out_chan   out  red_out, green_out, blue_out, last, status
//  cfg_chan   in   index, data (seed, start value, mode, pixel count)
//
// A load request writes its pixel as it is accepted; a read request passes
// through a read-wait state into the result register before the output
// hand-off. The last load of an image starts processing of d pixels, whose
// time is set mostly by the shuffle step around the bit-serial remainder;
// the three memories each have one write and one read port.
// No request is accepted while processing runs or a result waits on out_chan.
// Reset is synchronous; the memories are not cleared.
// ---------------------------------------------------------------------------
`include "image_permute_xor_cipher_unit_assert.svh"

module image_permute_xor_cipher_unit #(
  parameter int MAX_PIXELS = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  ipx_in_if.sink        in_chan,
  ipx_out_if.source     out_chan,
  ipx_cfg_if.sink       cfg_chan
);
  import ipx_pkg::*;

  localparam int AW   = $clog2(MAX_PIXELS);
  localparam int CW   = $clog2(MAX_PIXELS + 1);
  localparam int CMPW = (CW > PCOUNT_W) ? CW : PCOUNT_W;

  ipx_state_t state_r, state_nxt;

  logic [PRNG_W-1:0]   seed_r;
  logic [PRNG_W-1:0]   start_r;
  logic                dec_r;
  logic [PCOUNT_W-1:0] pcount_r;

  logic [PRNG_W-1:0] start_l_r,  start_l_nxt;
  logic              dec_l_r,    dec_l_nxt;
  logic [PRNG_W-1:0] prng_r,     prng_nxt;
  logic [PIX_W-1:0]  prev_r,     prev_nxt;
  logic [AW-1:0]     idx_r,      idx_nxt;
  logic [AW-1:0]     last_idx_r, last_idx_nxt;
  logic [AW-1:0]     t_r,        t_nxt;
  logic [CW-1:0]     lc_r,       lc_nxt;
  logic [CW-1:0]     rc_r,       rc_nxt;
  logic              ready_r,    ready_nxt;
  logic              plast_r,    plast_nxt;

  logic              ov_r,       ov_nxt;
  logic [PIX_W-1:0]  opix_r,     opix_nxt;
  logic              olast_r,    olast_nxt;
  logic [1:0]        ostat_r,    ostat_nxt;

  logic              in_ready;
  logic              in_fire;
  logic [CW-1:0]     lc_base;
  logic [CW-1:0]     lc_new;
  logic [PIX_W-1:0]  prng_key;

  // Memory ports.
  logic             pix_we,  ord_we,  res_we;
  logic [AW-1:0]    pix_wa,  ord_wa,  res_wa;
  logic [PIX_W-1:0] pix_wd,  res_wd;
  logic [AW-1:0]    ord_wd;
  logic [AW-1:0]    pix_ra,  ord_ra,  res_ra;
  logic [PIX_W-1:0] pix_rd,  res_rd;
  logic [AW-1:0]    ord_rd;

  // Remainder unit.
  logic              div_start;
  logic [PRNG_W-1:0] div_dividend;
  logic              div_busy;
  logic              div_done;
  logic [AW-1:0]     div_rem;

  ipx_ram #(.WIDTH(PIX_W), .DEPTH(MAX_PIXELS)) u_pixel_store (
    .clk(clk), .wr_en(pix_we), .wr_addr(pix_wa), .wr_data(pix_wd),
    .rd_addr(pix_ra), .rd_data(pix_rd)
  );

  ipx_ram #(.WIDTH(AW), .DEPTH(MAX_PIXELS)) u_order_table (
    .clk(clk), .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd),
    .rd_addr(ord_ra), .rd_data(ord_rd)
  );

  ipx_ram #(.WIDTH(PIX_W), .DEPTH(MAX_PIXELS)) u_result_store (
    .clk(clk), .wr_en(res_we), .wr_addr(res_wa), .wr_data(res_wd),
    .rd_addr(res_ra), .rd_data(res_rd)
  );

  ipx_mod_unit #(.VW(AW)) u_mod (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(idx_r), .busy(div_busy), .done(div_done), .rem(div_rem)
  );

  // Handshakes.
  assign in_ready       = (state_r == S_IDLE) && !ov_r;
  assign in_chan.ready  = in_ready;
  assign in_fire        = in_chan.valid && in_ready;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid     = ov_r;
  assign out_chan.red_out   = opix_r[23:16];
  assign out_chan.green_out = opix_r[15:8];
  assign out_chan.blue_out  = opix_r[7:0];
  assign out_chan.last      = olast_r;
  assign out_chan.status    = ostat_r;

  // A load after a finished image starts a new one.
  assign lc_base  = ready_r ? '0 : lc_r;
  assign lc_new   = lc_base + CW'(1);
  assign prng_key = key_mask(prng_r);

  // Sequencer: request handling and the processing passes.
  always_comb begin
    state_nxt    = state_r;
    start_l_nxt  = start_l_r;
    dec_l_nxt    = dec_l_r;
    prng_nxt     = prng_r;
    prev_nxt     = prev_r;
    idx_nxt      = idx_r;
    last_idx_nxt = last_idx_r;
    t_nxt        = t_r;
    lc_nxt       = lc_r;
    rc_nxt       = rc_r;
    ready_nxt    = ready_r;
    plast_nxt    = plast_r;
    ov_nxt       = ov_r;
    opix_nxt     = opix_r;
    olast_nxt    = olast_r;
    ostat_nxt    = ostat_r;

    pix_we = 1'b0; pix_wa = idx_r; pix_wd = '0; pix_ra = idx_r;
    ord_we = 1'b0; ord_wa = idx_r; ord_wd = idx_r; ord_ra = idx_r;
    res_we = 1'b0; res_wa = idx_r; res_wd = '0; res_ra = idx_r;
    div_start    = 1'b0;
    div_dividend = xs32(prng_r);

    if (ov_r && out_chan.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        res_ra = rc_r[AW-1:0];
        if (in_fire && in_chan.command == CMD_LOAD) begin
          if (ready_r) begin
            ready_nxt = 1'b0;
            rc_nxt    = '0;
          end
          if (lc_base != CW'(MAX_PIXELS)) begin
            pix_we = 1'b1;
            pix_wa = lc_base[AW-1:0];
            pix_wd = {in_chan.red, in_chan.green, in_chan.blue};
            lc_nxt = lc_new;
            if (CMPW'(lc_new) >= CMPW'(pcount_r) || lc_new == CW'(MAX_PIXELS)) begin
              start_l_nxt  = start_r;
              dec_l_nxt    = dec_r;
              prng_nxt     = seed_r;
              idx_nxt      = '0;
              last_idx_nxt = AW'(lc_base);
              state_nxt    = S_INIT;
            end
          end else begin
            lc_nxt = lc_base;
          end
        end else if (in_fire) begin
          ov_nxt    = !ready_r || rc_r >= lc_r;
          opix_nxt  = '0;
          olast_nxt = 1'b0;
          if (!ready_r) begin
            ostat_nxt = ST_NOT_LOADED;
          end else if (rc_r >= lc_r) begin
            ostat_nxt = ST_ALL_READ;
          end else begin
            ostat_nxt = ST_OK;
            plast_nxt = (rc_r + CW'(1)) == lc_r;
            rc_nxt    = rc_r + CW'(1);
            state_nxt = S_RD_WAIT;
          end
        end
      end

      S_RD_WAIT: begin
        ov_nxt    = 1'b1;
        opix_nxt  = res_rd;
        olast_nxt = plast_r;
        state_nxt = S_IDLE;
      end

      // Identity order, then shuffle from the top entry down.
      S_INIT: begin
        ord_we = 1'b1;
        if (idx_r == last_idx_r) begin
          if (last_idx_r == '0) begin
            prev_nxt  = key_mask(start_l_r);
            state_nxt = dec_l_r ? S_DC_RD : S_EP_RD;
          end else begin
            state_nxt = S_SH_STEP;
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end

      S_SH_STEP: begin
        prng_nxt  = xs32(prng_r);
        div_start = 1'b1;
        state_nxt = S_SH_DIV;
      end

      S_SH_DIV: begin
        ord_ra = div_rem;
        if (div_done) begin
          state_nxt = S_SH_RDI;
        end
      end

      S_SH_RDI: begin
        t_nxt     = ord_rd;
        state_nxt = S_SH_WR1;
      end

      S_SH_WR1: begin
        ord_we    = 1'b1;
        ord_wa    = div_rem;
        ord_wd    = ord_rd;
        state_nxt = S_SH_WR2;
      end

      S_SH_WR2: begin
        ord_we = 1'b1;
        ord_wd = t_r;
        if (idx_r == AW'(1)) begin
          idx_nxt   = '0;
          prev_nxt  = key_mask(start_l_r);
          state_nxt = dec_l_r ? S_DC_RD : S_EP_RD;
        end else begin
          idx_nxt   = idx_r - AW'(1);
          state_nxt = S_SH_STEP;
        end
      end

      // Encryption: scatter into the new order, then chain.
      S_EP_RD: begin
        state_nxt = S_EP_WR;
      end

      S_EP_WR: begin
        res_we = 1'b1;
        res_wa = ord_rd;
        res_wd = pix_rd;
        if (idx_r == last_idx_r) begin
          idx_nxt   = '0;
          state_nxt = S_EC_RD;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_EP_RD;
        end
      end

      S_EC_RD: begin
        prng_nxt  = xs32(prng_r);
        state_nxt = S_EC_WR;
      end

      S_EC_WR: begin
        res_we   = 1'b1;
        res_wd   = prev_r ^ res_rd ^ prng_key;
        prev_nxt = prev_r ^ res_rd ^ prng_key;
        if (idx_r == last_idx_r) begin
          ready_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_EC_RD;
        end
      end

      // Decryption: undo the chain in place, then gather.
      S_DC_RD: begin
        prng_nxt  = xs32(prng_r);
        state_nxt = S_DC_WR;
      end

      S_DC_WR: begin
        pix_we   = 1'b1;
        pix_wd   = prev_r ^ pix_rd ^ prng_key;
        prev_nxt = pix_rd;
        if (idx_r == last_idx_r) begin
          idx_nxt   = '0;
          state_nxt = S_DP_RD;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_DC_RD;
        end
      end

      S_DP_RD: begin
        state_nxt = S_DP_RD2;
      end

      S_DP_RD2: begin
        pix_ra    = ord_rd;
        state_nxt = S_DP_WR;
      end

      S_DP_WR: begin
        res_we = 1'b1;
        res_wd = pix_rd;
        if (idx_r == last_idx_r) begin
          ready_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_DP_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lc_r    <= '0;
      rc_r    <= '0;
      ready_r <= 1'b0;
      ov_r    <= 1'b0;
      prng_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lc_r    <= lc_nxt;
      rc_r    <= rc_nxt;
      ready_r <= ready_nxt;
      ov_r    <= ov_nxt;
      prng_r  <= prng_nxt;
    end
    start_l_r  <= start_l_nxt;
    dec_l_r    <= dec_l_nxt;
    prev_r     <= prev_nxt;
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
    t_r        <= t_nxt;
    plast_r    <= plast_nxt;
    opix_r     <= opix_nxt;
    olast_r    <= olast_nxt;
    ostat_r    <= ostat_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r   <= SEED_RESET;
      start_r  <= '0;
      dec_r    <= 1'b0;
      pcount_r <= PCOUNT_RESET;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_SEED:        seed_r   <= cfg_chan.data;
        REG_START_VALUE: start_r  <= cfg_chan.data;
        REG_DECRYPT:     dec_r    <= cfg_chan.data[0];
        REG_PIXEL_COUNT: pcount_r <= cfg_chan.data[PCOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Checks on the sequencer.
  `IPX_ASSERT_ALWAYS(a_read_within_load, rc_r <= lc_r)
  `IPX_ASSERT_SAME(a_idx_in_image, state_r != S_IDLE && state_r != S_RD_WAIT, idx_r <= last_idx_r)
  `IPX_ASSERT_SAME(a_div_start_free, div_start, !div_busy)
  `IPX_ASSERT_NEXT(a_read_gives_result, state_r == S_RD_WAIT, ov_r && state_r == S_IDLE)

endmodule

/* verif/image_permute_xor_cipher_unit_tb.sv */
// ---------------------------------------------------------------------------
// image_permute_xor_cipher_unit_tb
// Drives load and read requests and register writes into the image cipher,
// predicts each returned pixel with an independent model of the keystream,
// shuffle and XOR chain, and compares every result field by field.
// ---------------------------------------------------------------------------
module image_permute_xor_cipher_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ipx_pkg::*;

  localparam int MAX_PIX = 4096;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
    logic [1:0] status;
  } cipher_pixel_t;

  // Model of the cipher: image stores, keystream, counters and registers.
  class pixel_cipher_scoreboard;
    logic [31:0]   seed_reg;
    logic [31:0]   start_reg;
    logic          decrypt_reg;
    logic [12:0]   count_reg;
    logic [23:0]   plain_mem[MAX_PIX];
    logic [23:0]   cipher_mem[MAX_PIX];
    int unsigned   order[MAX_PIX];
    int unsigned   loaded;
    int unsigned   returned;
    bit            ready_flag;
    int unsigned   work_pixels;
    int unsigned   errors;
    cipher_pixel_t pending_pixels[$];

    function new();
      seed_reg    = SEED_RESET;
      start_reg   = '0;
      decrypt_reg = 1'b0;
      count_reg   = PCOUNT_RESET;
      loaded      = 0;
      returned    = 0;
      ready_flag  = 1'b0;
      work_pixels = 0;
      errors      = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] data);
      case (idx)
        REG_SEED:        seed_reg = data;
        REG_START_VALUE: start_reg = data;
        REG_DECRYPT:     decrypt_reg = data[0];
        REG_PIXEL_COUNT: count_reg = data[12:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] advance(logic [31:0] x);
      logic [31:0] v;
      v = x ^ {x[18:0], 13'd0};
      v = v ^ {17'd0, v[31:17]};
      v = v ^ {v[26:0], 5'd0};
      return v;
    endfunction

    function logic [23:0] whiten(logic [31:0] w);
      return {w[15:8], w[23:16], w[31:24]};
    endfunction

    // Shuffle, then chain (encrypt) or unchain and unshuffle (decrypt).
    function void run_cipher();
      int unsigned d, r, t;
      logic [31:0] x;
      logic [23:0] prev, cur;
      d = loaded;
      for (int i = 0; i < d; i++) order[i] = i;
      x = seed_reg;
      for (int i = d - 1; i >= 1; i--) begin
        x = advance(x);
        r = x % i;
        t = order[r];
        order[r] = order[i];
        order[i] = t;
      end
      if (!decrypt_reg) begin
        for (int i = 0; i < d; i++) cipher_mem[order[i]] = plain_mem[i];
        for (int k = 0; k < d; k++) begin
          x = advance(x);
          prev = (k == 0) ? whiten(start_reg) : cipher_mem[k-1];
          cipher_mem[k] = prev ^ cipher_mem[k] ^ whiten(x);
        end
      end else begin
        prev = whiten(start_reg);
        for (int k = 0; k < d; k++) begin
          cur = plain_mem[k];
          x = advance(x);
          plain_mem[k] = prev ^ cur ^ whiten(x);
          prev = cur;
        end
        for (int i = 0; i < d; i++) cipher_mem[i] = plain_mem[order[i]];
      end
      ready_flag = 1'b1;
      work_pixels = d;
    endfunction

    // Called for every accepted request.
    function void note_request(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      cipher_pixel_t exp_pix;
      int unsigned lim;
      work_pixels = 0;
      if (cmd == CMD_LOAD) begin
        if (ready_flag) begin
          ready_flag = 1'b0;
          loaded = 0;
          returned = 0;
        end
        if (loaded < MAX_PIX) begin
          plain_mem[loaded] = {r, g, b};
          loaded++;
        end
        lim = (count_reg == 0) ? 1 : ((count_reg > MAX_PIX) ? MAX_PIX : count_reg);
        if (loaded >= lim) run_cipher();
        return;
      end
      exp_pix = '0;
      if (!ready_flag) begin
        exp_pix.status = ST_NOT_LOADED;
      end else if (returned >= loaded) begin
        exp_pix.status = ST_ALL_READ;
      end else begin
        {exp_pix.red, exp_pix.green, exp_pix.blue} = cipher_mem[returned];
        exp_pix.last = (returned + 1 == loaded);
        exp_pix.status = ST_OK;
        returned++;
      end
      pending_pixels.push_back(exp_pix);
    endfunction

    function void check_result(cipher_pixel_t got);
      cipher_pixel_t exp_pix;
      if (pending_pixels.size() == 0) begin
        $error("unexpected result pixel %h", got);
        errors++;
        return;
      end
      exp_pix = pending_pixels.pop_front();
      if (got.red !== exp_pix.red) begin
        $error("red_out: expected %h, got %h", exp_pix.red, got.red);
        errors++;
      end
      if (got.green !== exp_pix.green) begin
        $error("green_out: expected %h, got %h", exp_pix.green, got.green);
        errors++;
      end
      if (got.blue !== exp_pix.blue) begin
        $error("blue_out: expected %h, got %h", exp_pix.blue, got.blue);
        errors++;
      end
      if (got.last !== exp_pix.last) begin
        $error("last: expected %b, got %b", exp_pix.last, got.last);
        errors++;
      end
      if (got.status !== exp_pix.status) begin
        $error("status: expected %0d, got %0d", exp_pix.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  ipx_in_if  in_if();
  ipx_out_if out_if();
  ipx_cfg_if cfg_if();

  pixel_cipher_scoreboard sb = new();
  bit no_gaps;
  int unsigned request_total;

  image_permute_xor_cipher_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("image_permute_xor_cipher_unit verification failed");
    $finish;
  end

  // Result sink with random stalls; checks at the rising edge.
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = no_gaps ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid && out_if.ready));
      sb.check_result({out_if.red_out, out_if.green_out, out_if.blue_out,
                       out_if.last, out_if.status});
    end
  end

  // One request; valid stays high so that a gapless next request follows on.
  task automatic send_request(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.red     <= r;
    in_if.green   <= g;
    in_if.blue    <= b;
    do @(posedge clk); while (!in_if.ready);
    sb.note_request(cmd, r, g, b);
    request_total++;
    @(negedge clk);
  endtask

  task automatic load_pixel(logic [23:0] p);
    send_request(CMD_LOAD, p[23:16], p[15:8], p[7:0]);
  endtask

  task automatic read_pixel();
    send_request(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Waits until every result is back and any processing has finished.
  task automatic wait_idle();
    int unsigned extra;
    in_if.valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    extra = sb.work_pixels * 45 + 40;
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [23:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      default: return 24'($urandom);
    endcase
  endfunction

  // Stimulus.
  initial begin
    int unsigned d;
    logic [31:0] cnt_word;
    rst_n = 1'b0;
    no_gaps = 1'b0;
    request_total = 0;
    in_if.valid = 1'b0;
    in_if.command = CMD_LOAD;
    in_if.red = '0;
    in_if.green = '0;
    in_if.blue = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: read before any image has been loaded.
    read_pixel();
    wait_idle();

    // Single-pixel image with an all-zero seed, read past its end.
    write_reg(REG_PIXEL_COUNT, 32'd1);
    write_reg(REG_SEED, 32'd0);
    load_pixel(24'hFFFFFF);
    read_pixel();
    read_pixel();
    wait_idle();

    // Pixel count of zero behaves as one.
    write_reg(REG_PIXEL_COUNT, 32'd0);
    load_pixel(24'h000000);
    read_pixel();
    wait_idle();

    // Decrypt with all-ones keys; pixel count lowered part way through a load.
    write_reg(REG_SEED, 32'hFFFF_FFFF);
    write_reg(REG_START_VALUE, 32'hFFFF_FFFF);
    write_reg(REG_DECRYPT, 32'd1);
    write_reg(REG_PIXEL_COUNT, 32'd5);
    repeat (3) load_pixel(rand_pixel());
    wait_idle();
    write_reg(REG_PIXEL_COUNT, 32'd2);
    load_pixel(rand_pixel());
    repeat (5) read_pixel();
    wait_idle();

    // A new image started before the previous one has been read out.
    write_reg(REG_DECRYPT, 32'd0);
    write_reg(REG_PIXEL_COUNT, 32'd3);
    repeat (3) load_pixel(rand_pixel());
    read_pixel();
    repeat (3) load_pixel(rand_pixel());
    repeat (4) read_pixel();
    wait_idle();

    // Count written above the maximum holds off processing until lowered.
    write_reg(REG_SEED, $urandom);
    write_reg(REG_START_VALUE, $urandom);
    write_reg(REG_PIXEL_COUNT, 32'hFFFF_FFFF);
    repeat (20) load_pixel(rand_pixel());
    wait_idle();
    write_reg(REG_PIXEL_COUNT, 32'd4);
    load_pixel(rand_pixel());
    repeat (22) read_pixel();
    wait_idle();

    // Random images, mostly small.
    while (request_total < 1450) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) write_reg(REG_SEED, $urandom);
      if ($urandom_range(0, 1)) write_reg(REG_START_VALUE, $urandom);
      if ($urandom_range(0, 1)) write_reg(REG_DECRYPT, $urandom);
      case ($urandom_range(0, 9))
        0:       d = $urandom_range(1, 2);
        1, 2:    d = $urandom_range(25, 120);
        default: d = $urandom_range(3, 24);
      endcase
      cnt_word = {$urandom_range(0, 1) ? 19'($urandom) : 19'd0, 13'(d)};
      write_reg(REG_PIXEL_COUNT, cnt_word);
      if ($urandom_range(0, 4) == 0) read_pixel();
      for (int i = 0; i < d; i++) begin
        load_pixel(rand_pixel());
        if ($urandom_range(0, 30) == 0 && i + 1 < d) read_pixel();
      end
      repeat (d + $urandom_range(0, 2)) read_pixel();
      wait_idle();
    end

    no_gaps = 1'b0;
    wait_idle();
    if (sb.errors == 0) begin
      $display("image_permute_xor_cipher_unit verification clean");
    end else begin
      $display("image_permute_xor_cipher_unit verification failed");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ipx_pkg.sv
rtl/core/ipx_if.sv
rtl/core/ipx_ram.sv
rtl/core/ipx_mod_unit.sv
rtl/core/image_permute_xor_cipher_unit.sv
verif/image_permute_xor_cipher_unit_tb.sv
